/* rtl/core/crs_pkg.sv */
// Shared definitions for the cubic interpolating resampler.
// Holds default widths, the result cap, register indexes, the sequencer
// state type and the control group passed to the datapath modules.
package crs_pkg;

    localparam int CRS_SAMPLE_BITS   = 16;
    localparam int CRS_FRACTION_BITS = 16;
    localparam int CRS_MAX_RESULTS   = 48;
    localparam int CRS_CNT_W         = $clog2(CRS_MAX_RESULTS + 1);
    localparam int CRS_LEN_W         = 16;
    localparam int CRS_STEP_W        = 24;
    localparam int CRS_ACC_W         = 32;
    localparam int CRS_CFG_IDX_W     = 2;
    localparam int CRS_TAPS          = 4;

    typedef enum logic [CRS_CFG_IDX_W-1:0] {
        REG_BLOCK_IN_LEN  = 2'd0,
        REG_BLOCK_OUT_LEN = 2'd1,
        REG_POSITION_STEP = 2'd2
    } crs_reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL1,
        ST_MUL2,
        ST_WGT,
        ST_PROD,
        ST_SUM,
        ST_OUT,
        ST_FIN
    } crs_state_t;

    // Load enables for the datapath steps of one output.
    typedef struct packed {
        logic mul1;
        logic mul2;
        logic wgt;
        logic prod;
        logic sum;
    } crs_ctrl_t;

endpackage

/* rtl/core/crs_coef.sv */
// Catmull-Rom weight unit: forms t^2, t^3 and the four tap weights over
// three sequencer steps. Depends on crs_pkg for the control group.
module crs_coef #(
    parameter int FRACTION_BITS = crs_pkg::CRS_FRACTION_BITS,
    parameter int W_W           = FRACTION_BITS + 4
) (
    input  logic                        aclk,
    input  crs_pkg::crs_ctrl_t          ctrl,
    input  logic [FRACTION_BITS-1:0]    frac,
    output logic signed [W_W-1:0]       weight [crs_pkg::CRS_TAPS]
);
    import crs_pkg::*;

    localparam int F = FRACTION_BITS;

    logic [F-1:0]   t2_reg;
    logic [F-1:0]   t3_reg;
    logic [2*F-1:0] sq;
    logic [2*F-1:0] cube;
    logic signed [W_W-1:0] te, t2e, t3e;
    logic signed [W_W-1:0] w_next [CRS_TAPS];
    logic signed [W_W-1:0] w_reg  [CRS_TAPS];

    localparam logic signed [W_W-1:0] TWO_ONE = W_W'(2) <<< F;

    assign sq   = (2*F)'(frac) * (2*F)'(frac);
    assign cube = (2*F)'(t2_reg) * (2*F)'(frac);

    assign te  = $signed({4'b0000, frac});
    assign t2e = $signed({4'b0000, t2_reg});
    assign t3e = $signed({4'b0000, t3_reg});

    always_comb begin
        w_next[0] = (t2e <<< 1) - t3e - te;
        w_next[1] = (t3e <<< 1) + t3e - (t2e <<< 2) - t2e + TWO_ONE;
        w_next[2] = (t2e <<< 2) + te - (t3e <<< 1) - t3e;
        w_next[3] = t3e - t2e;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul1) begin
            t2_reg <= sq[2*F-1:F];
        end
        if (ctrl.mul2) begin
            t3_reg <= cube[2*F-1:F];
        end
        if (ctrl.wgt) begin
            for (int k = 0; k < CRS_TAPS; k++) begin
                w_reg[k] <= w_next[k];
            end
        end
    end

    assign weight = w_reg;

endmodule

/* rtl/core/crs_lane.sv */
// One tap lane: multiplies its weight by the real and imaginary parts of
// its neighbour sample and registers both products. Depends on crs_pkg.
module crs_lane #(
    parameter int SAMPLE_BITS   = crs_pkg::CRS_SAMPLE_BITS,
    parameter int FRACTION_BITS = crs_pkg::CRS_FRACTION_BITS,
    parameter int W_W           = FRACTION_BITS + 4,
    parameter int PW            = W_W + SAMPLE_BITS
) (
    input  logic                          aclk,
    input  crs_pkg::crs_ctrl_t            ctrl,
    input  logic signed [W_W-1:0]         weight,
    input  logic signed [SAMPLE_BITS-1:0] x_re,
    input  logic signed [SAMPLE_BITS-1:0] x_im,
    output logic signed [PW-1:0]          p_re,
    output logic signed [PW-1:0]          p_im
);
    import crs_pkg::*;

    logic signed [PW-1:0] p_re_reg, p_im_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.prod) begin
            p_re_reg <= PW'(weight) * PW'(x_re);
            p_im_reg <= PW'(weight) * PW'(x_im);
        end
    end

    assign p_re = p_re_reg;
    assign p_im = p_im_reg;

endmodule

/* rtl/core/crs_merge.sv */
// Merging stage: adds the four lane products of each component, rounds
// half up, drops the weight scale and saturates. Depends on crs_pkg.
module crs_merge #(
    parameter int SAMPLE_BITS   = crs_pkg::CRS_SAMPLE_BITS,
    parameter int FRACTION_BITS = crs_pkg::CRS_FRACTION_BITS,
    parameter int PW            = FRACTION_BITS + 4 + SAMPLE_BITS
) (
    input  logic                          aclk,
    input  crs_pkg::crs_ctrl_t            ctrl,
    input  logic signed [PW-1:0]          p_re [crs_pkg::CRS_TAPS],
    input  logic signed [PW-1:0]          p_im [crs_pkg::CRS_TAPS],
    output logic signed [SAMPLE_BITS-1:0] out_re,
    output logic signed [SAMPLE_BITS-1:0] out_im
);
    import crs_pkg::*;

    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HALF   = SW'(1) <<< FRACTION_BITS;
    localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [SW-1:0] sum_re, sum_im, sh_re, sh_im;
    logic signed [SAMPLE_BITS-1:0] sat_re, sat_im;
    logic signed [SAMPLE_BITS-1:0] out_re_reg, out_im_reg;

    always_comb begin
        sum_re = HALF;
        sum_im = HALF;
        for (int k = 0; k < CRS_TAPS; k++) begin
            sum_re = sum_re + SW'(p_re[k]);
            sum_im = sum_im + SW'(p_im[k]);
        end
        // Arithmetic shift gives the floor of the scaled sum.
        sh_re = sum_re >>> (FRACTION_BITS + 1);
        sh_im = sum_im >>> (FRACTION_BITS + 1);
        if (sh_re > SAT_HI) begin
            sat_re = SAMPLE_BITS'(SAT_HI);
        end else if (sh_re < SAT_LO) begin
            sat_re = SAMPLE_BITS'(SAT_LO);
        end else begin
            sat_re = sh_re[SAMPLE_BITS-1:0];
        end
        if (sh_im > SAT_HI) begin
            sat_im = SAMPLE_BITS'(SAT_HI);
        end else if (sh_im < SAT_LO) begin
            sat_im = SAMPLE_BITS'(SAT_LO);
        end else begin
            sat_im = sh_im[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sum) begin
            out_re_reg <= sat_re;
            out_im_reg <= sat_im;
        end
    end

    assign out_re = out_re_reg;
    assign out_im = out_im_reg;

endmodule

/* rtl/core/cubic_interpolating_resampler_top.sv */
// Top level of the cubic interpolating resampler: sample window, block
// counters, output sequencer and the weight, lane and merge datapath.
// Depends on crs_pkg, crs_coef, crs_lane and crs_merge.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_tvalid/s_tready   s_tdata = {sample_im, sample_re}
//  m_        out        m_tvalid/m_tready   m_tdata = {out_im, out_re},
//                                           m_tlast = run_last, m_tuser = block_last
//  cfg_      in         cfg_we              cfg_index, cfg_wdata
//
// An item is taken in the idle state, then passes a readiness-check state and a
// closing state; each output it causes adds the steps t^2, t^3, weights, lane
// products, merge and output. s_tready is high only in the idle state, so a new
// item waits until the last is finished; while an output waits on m_tready the
// sequencer holds. Synchronous active-low reset clears the window and counters
// and restores the register defaults.
module cubic_interpolating_resampler_top #(
    parameter int SAMPLE_BITS   = crs_pkg::CRS_SAMPLE_BITS,
    parameter int FRACTION_BITS = crs_pkg::CRS_FRACTION_BITS,
    parameter int DATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_re [SAMPLE_BITS-1:0], sample_im next, zero fill above
    input  logic [DATA_W-1:0]                  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_re [SAMPLE_BITS-1:0], out_im next, zero fill above
    output logic [DATA_W-1:0]                  m_tdata,
    output logic                               m_tlast,
    // block_last
    output logic                               m_tuser,
    input  logic                               cfg_we,
    input  logic [crs_pkg::CRS_CFG_IDX_W-1:0]  cfg_index,
    input  logic [crs_pkg::CRS_STEP_W-1:0]     cfg_wdata
);
    import crs_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int IDX_W = CRS_ACC_W - F;
    localparam int CMP_W = ((IDX_W > CRS_LEN_W) ? IDX_W : CRS_LEN_W) + 2;
    localparam int W_W   = F + 4;
    localparam int PW    = W_W + SB;

    crs_state_t state_reg, state_next;
    crs_ctrl_t  ctrl;

    logic [CRS_LEN_W-1:0]  in_len_reg, out_len_reg;
    logic [CRS_STEP_W-1:0] step_reg;

    logic signed [SB-1:0] win_re_reg [CRS_TAPS];
    logic signed [SB-1:0] win_im_reg [CRS_TAPS];
    logic signed [SB-1:0] sel_re_reg [CRS_TAPS];
    logic signed [SB-1:0] sel_im_reg [CRS_TAPS];

    logic [CRS_LEN_W-1:0] seen_reg, done_reg;
    logic [CRS_ACC_W-1:0] accum_reg;
    logic [CRS_CNT_W-1:0] count_reg;
    logic                 last_in_reg, next_ready_reg, run_last_reg, block_last_reg;

    logic [CRS_LEN_W-1:0] len_eff, olen_eff, len_m1;
    logic [CRS_ACC_W-1:0] accum_step;
    logic                 cur_ok, nxt_ok, s_fire;
    logic [1:0]           slot [CRS_TAPS];

    logic signed [W_W-1:0] weight [CRS_TAPS];
    logic signed [PW-1:0]  p_re [CRS_TAPS];
    logic signed [PW-1:0]  p_im [CRS_TAPS];
    logic signed [SB-1:0]  out_re, out_im;

    function automatic logic pos_ready(input logic [CRS_ACC_W-1:0] acc,
                                       input logic [CRS_LEN_W-1:0] lim_in,
                                       input logic [CRS_LEN_W-1:0] n);
        logic [CMP_W-1:0] need;
        logic [CMP_W-1:0] lim;
        need = CMP_W'(acc[CRS_ACC_W-1:F]) + CMP_W'(2);
        lim  = CMP_W'(lim_in);
        if (need > lim) begin
            need = lim;
        end
        return need <= CMP_W'(n);
    endfunction

    assign len_eff    = (in_len_reg == '0) ? CRS_LEN_W'(1) : in_len_reg;
    assign olen_eff   = (out_len_reg == '0) ? CRS_LEN_W'(1) : out_len_reg;
    assign len_m1     = len_eff - CRS_LEN_W'(1);
    assign accum_step = accum_reg + CRS_ACC_W'(step_reg);

    assign cur_ok = (count_reg < CRS_CNT_W'(CRS_MAX_RESULTS)) && (done_reg < olen_eff)
                  && pos_ready(accum_reg, len_m1, seen_reg);
    assign nxt_ok = ((CRS_CNT_W + 1)'(count_reg) + (CRS_CNT_W + 1)'(1)
                     < (CRS_CNT_W + 1)'(CRS_MAX_RESULTS))
                  && ((CRS_LEN_W + 1)'(done_reg) + (CRS_LEN_W + 1)'(1)
                     < (CRS_LEN_W + 1)'(olen_eff))
                  && pos_ready(accum_step, len_m1, seen_reg);

    assign s_fire = s_tvalid && s_tready;

    // Window slot for each tap: neighbour index clamped to the block, then
    // its age clamped to the window depth.
    always_comb begin
        logic signed [CMP_W:0] pos, c, off, lim_s, n_s;
        lim_s = $signed({1'b0, CMP_W'(len_m1)});
        n_s   = $signed({1'b0, CMP_W'(seen_reg)});
        for (int k = 0; k < CRS_TAPS; k++) begin
            pos = $signed({1'b0, CMP_W'(accum_reg[CRS_ACC_W-1:F])})
                - (CMP_W + 1)'(1) + (CMP_W + 1)'(k);
            c = (pos > lim_s) ? lim_s : pos;
            if (c < (CMP_W + 1)'(0)) begin
                c = '0;
            end
            off = n_s - c;
            if (off < (CMP_W + 1)'(0)) begin
                off = '0;
            end
            if (off > (CMP_W + 1)'(3)) begin
                off = (CMP_W + 1)'(3);
            end
            slot[k] = off[1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_CHECK;
            ST_CHECK: state_next = cur_ok ? ST_MUL1 : ST_FIN;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_WGT;
            ST_WGT:   state_next = ST_PROD;
            ST_PROD:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    state_next = run_last_reg ? ST_FIN : ST_MUL1;
                end
            end
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_MUL1: ctrl.mul1 = 1'b1;
            ST_MUL2: ctrl.mul2 = 1'b1;
            ST_WGT:  ctrl.wgt  = 1'b1;
            ST_PROD: ctrl.prod = 1'b1;
            ST_SUM:  ctrl.sum  = 1'b1;
            ST_OUT:  m_tvalid  = 1'b1;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_len_reg     <= CRS_LEN_W'(1024);
            out_len_reg    <= CRS_LEN_W'(1024);
            step_reg       <= CRS_STEP_W'(65536);
            seen_reg       <= '0;
            done_reg       <= '0;
            accum_reg      <= '0;
            count_reg      <= '0;
            last_in_reg    <= 1'b0;
            next_ready_reg <= 1'b0;
            run_last_reg   <= 1'b0;
            block_last_reg <= 1'b0;
            for (int k = 0; k < CRS_TAPS; k++) begin
                win_re_reg[k] <= '0;
                win_im_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_BLOCK_IN_LEN:  in_len_reg  <= cfg_wdata[CRS_LEN_W-1:0];
                    REG_BLOCK_OUT_LEN: out_len_reg <= cfg_wdata[CRS_LEN_W-1:0];
                    REG_POSITION_STEP: step_reg    <= cfg_wdata;
                    default:           step_reg    <= step_reg;
                endcase
            end
            if (s_fire) begin
                for (int k = CRS_TAPS - 1; k > 0; k--) begin
                    win_re_reg[k] <= win_re_reg[k-1];
                    win_im_reg[k] <= win_im_reg[k-1];
                end
                win_re_reg[0] <= $signed(s_tdata[SB-1:0]);
                win_im_reg[0] <= $signed(s_tdata[2*SB-1:SB]);
                count_reg     <= '0;
                last_in_reg   <= ((CRS_LEN_W + 1)'(seen_reg) + (CRS_LEN_W + 1)'(1))
                                 >= (CRS_LEN_W + 1)'(len_eff);
            end
            if (state_reg == ST_WGT) begin
                next_ready_reg <= nxt_ok;
            end
            if (state_reg == ST_SUM) begin
                done_reg       <= done_reg + CRS_LEN_W'(1);
                accum_reg      <= accum_step;
                count_reg      <= count_reg + CRS_CNT_W'(1);
                run_last_reg   <= !next_ready_reg;
                block_last_reg <= ((CRS_LEN_W + 1)'(done_reg) + (CRS_LEN_W + 1)'(1)
                                   >= (CRS_LEN_W + 1)'(olen_eff))
                                || (!next_ready_reg && last_in_reg);
            end
            if (state_reg == ST_FIN) begin
                if (last_in_reg) begin
                    seen_reg  <= '0;
                    done_reg  <= '0;
                    accum_reg <= '0;
                end else begin
                    seen_reg <= seen_reg + CRS_LEN_W'(1);
                end
            end
        end
    end

    // Neighbour samples are latched so the lanes see a steady operand.
    always_ff @(posedge aclk) begin
        if (ctrl.wgt) begin
            for (int k = 0; k < CRS_TAPS; k++) begin
                sel_re_reg[k] <= win_re_reg[slot[k]];
                sel_im_reg[k] <= win_im_reg[slot[k]];
            end
        end
    end

    crs_coef #(
        .FRACTION_BITS (F),
        .W_W           (W_W)
    ) u_coef (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .frac   (accum_reg[F-1:0]),
        .weight (weight)
    );

    for (genvar g = 0; g < CRS_TAPS; g++) begin : g_lane
        crs_lane #(
            .SAMPLE_BITS   (SB),
            .FRACTION_BITS (F),
            .W_W           (W_W),
            .PW            (PW)
        ) u_lane (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .weight (weight[g]),
            .x_re   (sel_re_reg[g]),
            .x_im   (sel_im_reg[g]),
            .p_re   (p_re[g]),
            .p_im   (p_im[g])
        );
    end

    crs_merge #(
        .SAMPLE_BITS   (SB),
        .FRACTION_BITS (F),
        .PW            (PW)
    ) u_merge (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .p_re   (p_re),
        .p_im   (p_im),
        .out_re (out_re),
        .out_im (out_im)
    );

    assign m_tdata = DATA_W'({out_im, out_re});
    assign m_tlast = run_last_reg;
    assign m_tuser = block_last_reg;

endmodule

/* sim/cubic_interpolating_resampler_top_tb.sv */
// Self-checking testbench for cubic_interpolating_resampler_top: a directed table, then random
// blocks and register settings; outputs are checked against a built-in Catmull-Rom predictor
// or against values given in the table. Depends on crs_pkg and the resampler RTL only.
`timescale 1ns / 100ps

module cubic_interpolating_resampler_top_tb;

    import crs_pkg::*;

    localparam int          SETTLE_CYCLES  = 16;
    localparam int          DRAIN_CYCLES   = 64;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_ITEMS   = 100;
    localparam int          N_DIRECTED     = 39;
    localparam logic [1:0]  REG_NONE       = 2'd3;
    localparam logic [15:0] P_MAX          = 16'h7FFF;
    localparam logic [15:0] N_MAX          = 16'h8000;
    localparam logic [15:0] ZERO           = 16'h0000;
    localparam logic [31:0] FRAC_MASK      = (32'd1 << CRS_FRACTION_BITS) - 32'd1;
    localparam longint      UNITY          = longint'(1) << CRS_FRACTION_BITS;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic        run_last;
        logic        block_last;
    } out_sample_t;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  index;
        logic [23:0] value;
        logic [15:0] re;
        logic [15:0] im;
        logic        typed;
        out_sample_t want;
    } row_t;

    localparam out_sample_t NO_CHECK = '0;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_wdata = '0;

    // Predictor copy of the registers and block state.
    logic [15:0] in_len_reg   = 16'd1024;
    logic [15:0] out_len_reg  = 16'd1024;
    logic [23:0] step_reg     = 24'd65536;
    logic [15:0] samples_seen = '0;
    logic [15:0] outputs_done = '0;
    logic [31:0] pos_accum    = '0;
    shortint     win_re [4]   = '{0, 0, 0, 0};
    shortint     win_im [4]   = '{0, 0, 0, 0};

    out_sample_t expected_outputs [$];
    out_sample_t new_outputs [$];
    int unsigned mismatches        = 0;
    int unsigned outputs_checked   = 0;
    int          burst_left        = 0;
    int          ready_span        = 0;
    int          ready_mode        = 0;
    int          idle_cycles       = 0;

    row_t directed_rows [0:N_DIRECTED-1] = '{
        // Longest block, unit step: each output copies the sample two places back.
        '{ROW_WRITE,  REG_BLOCK_IN_LEN,  24'h00FFFF, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, P_MAX, N_MAX, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, N_MAX, P_MAX, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h1234, 16'hFFFF, 1'b1, '{P_MAX, N_MAX, 1'b1, 1'b0}},
        '{ROW_SAMPLE, REG_NONE, 24'h0, ZERO, ZERO, 1'b1, '{N_MAX, P_MAX, 1'b1, 1'b0}},
        // Shrink the block below the count already seen, so the next sample closes it;
        // the backlog of ready outputs hits the cap and the rest is dropped.
        '{ROW_WRITE,  REG_BLOCK_IN_LEN,  24'hFF0003, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h0001, 16'h0002, 1'b0, NO_CHECK},
        // Zero lengths act as one: every sample is a whole block with a single output.
        '{ROW_WRITE,  REG_BLOCK_IN_LEN,  24'h000000, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_BLOCK_OUT_LEN, 24'h000000, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_POSITION_STEP, 24'h000000, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, N_MAX, P_MAX, 1'b1, '{N_MAX, P_MAX, 1'b1, 1'b1}},
        '{ROW_SAMPLE, REG_NONE, 24'h0, P_MAX, ZERO, 1'b1, '{P_MAX, ZERO, 1'b1, 1'b1}},
        // Zero step: all outputs sit at position zero, so they pile up beyond the cap,
        // old neighbours fall out of the window, and the last sample finds the block done.
        '{ROW_WRITE,  REG_BLOCK_IN_LEN,  24'd8,   ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_BLOCK_OUT_LEN, 24'd200, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h0100, 16'hFF00, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h7F00, 16'h80FF, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'hC000, 16'h4000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h0FF0, 16'hF00F, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h3333, 16'hCCCC, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h5A5A, 16'hA5A5, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h0001, 16'hFFFE, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h8001, 16'h7FFE, 1'b0, NO_CHECK},
        // An index past the register list is ignored. Half step over alternating
        // extremes makes the cubic overshoot, so some outputs must saturate.
        '{ROW_WRITE,  REG_NONE,          24'hFFFFFF, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_BLOCK_IN_LEN,  24'd6,      ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_BLOCK_OUT_LEN, 24'd12,     ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_POSITION_STEP, 24'h008000, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, N_MAX, P_MAX, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, P_MAX, N_MAX, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, P_MAX, N_MAX, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, N_MAX, P_MAX, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, N_MAX, P_MAX, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, P_MAX, N_MAX, 1'b0, NO_CHECK},
        // Largest step and output count: every output after the first waits for
        // the final sample, which then cuts the block at the cap.
        '{ROW_WRITE,  REG_POSITION_STEP, 24'hFFFFFF, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_BLOCK_IN_LEN,  24'd4,      ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_BLOCK_OUT_LEN, 24'h00FFFF, ZERO, ZERO, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h0F0F, 16'hF0F0, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'hF0F0, 16'h0F0F, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'h2468, 16'hDB97, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_NONE, 24'h0, 16'hECA8, 16'h1357, 1'b0, NO_CHECK}
    };

    cubic_interpolating_resampler_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Round half up at scale 2^(F+1), then clamp to Q1.15.
    function automatic logic [15:0] round_saturate(input longint acc);
        longint v;
        v = (acc + UNITY) >>> (CRS_FRACTION_BITS + 1);
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // Shifts a sample into the window and collects the outputs it makes ready.
    function automatic void interpolate_sample(input logic [15:0] re, input logic [15:0] im);
        longint      len, olen, n, idx, need, c, t, t2, t3, acc_re, acc_im;
        longint      w [4];
        int          off;
        bit          last_in;
        out_sample_t r;
        len     = (in_len_reg == 16'd0) ? 1 : longint'(in_len_reg);
        olen    = (out_len_reg == 16'd0) ? 1 : longint'(out_len_reg);
        n       = longint'(samples_seen);
        last_in = (n + 1 >= len);
        for (int k = 3; k > 0; k--) begin
            win_re[k] = win_re[k-1];
            win_im[k] = win_im[k-1];
        end
        win_re[0] = shortint'(re);
        win_im[0] = shortint'(im);
        new_outputs.delete();
        while (new_outputs.size() < CRS_MAX_RESULTS && longint'(outputs_done) < olen) begin
            idx  = longint'(pos_accum >> CRS_FRACTION_BITS);
            need = (idx + 2 > len - 1) ? len - 1 : idx + 2;
            if (need > n)
                break;
            t    = longint'(pos_accum & FRAC_MASK);
            t2   = (t * t) >>> CRS_FRACTION_BITS;
            t3   = (t2 * t) >>> CRS_FRACTION_BITS;
            w[0] = -t3 + 2 * t2 - t;
            w[1] = 3 * t3 - 5 * t2 + 2 * UNITY;
            w[2] = -3 * t3 + 4 * t2 + t;
            w[3] = t3 - t2;
            acc_re = 0;
            acc_im = 0;
            for (int k = 0; k < 4; k++) begin
                c = idx - 1 + k;
                if (c > len - 1)
                    c = len - 1;
                if (c < 0)
                    c = 0;
                // Neighbours older than the window read its oldest slot.
                off = (n - c > 3) ? 3 : (n - c < 0) ? 0 : int'(n - c);
                acc_re += w[k] * longint'(win_re[off]);
                acc_im += w[k] * longint'(win_im[off]);
            end
            outputs_done = outputs_done + 16'd1;
            r.re         = round_saturate(acc_re);
            r.im         = round_saturate(acc_im);
            r.run_last   = 1'b0;
            r.block_last = (longint'(outputs_done) >= olen);
            pos_accum    = pos_accum + 32'(step_reg);
            new_outputs.push_back(r);
        end
        if (new_outputs.size() > 0) begin
            r = new_outputs.pop_back();
            r.run_last = 1'b1;
            if (last_in)
                r.block_last = 1'b1;
            new_outputs.push_back(r);
        end
        if (last_in) begin
            samples_seen = '0;
            outputs_done = '0;
            pos_accum    = '0;
        end else begin
            samples_seen = samples_seen + 16'd1;
        end
    endfunction

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return P_MAX;
            1: return N_MAX;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] output %0d: %s", $time, outputs_checked, what);
    endtask

    // Holds the sender off until every expected output has arrived, then lets the
    // block finish any item that makes no output.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 15) == 0) begin
                settle();
            end else begin
                gap = $urandom_range(0, 5);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
    endtask

    task automatic send_sample(input logic [15:0] re, input logic [15:0] im,
                               input logic typed, input out_sample_t want);
        pace_sender();
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        interpolate_sample(re, im);
        if (typed)
            expected_outputs.push_back(want);
        else
            foreach (new_outputs[i])
                expected_outputs.push_back(new_outputs[i]);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write of a group.
    task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            REG_BLOCK_IN_LEN:  in_len_reg  = value[15:0];
            REG_BLOCK_OUT_LEN: out_len_reg = value[15:0];
            REG_POSITION_STEP: step_reg    = value;
            default: ;
        endcase
    endtask

    // Receiver: stretches of steady readiness, random stalls and a fixed beat.
    always @(posedge aclk) begin
        if (ready_span == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_span = $urandom_range(8, 64);
        end else begin
            ready_span--;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ready_span[2];
        endcase
    end

    always @(posedge aclk) begin
        out_sample_t exp_out;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected output %h", m_tdata));
            end else begin
                exp_out = expected_outputs.pop_front();
                if (m_tdata[15:0] !== exp_out.re)
                    report_mismatch($sformatf("out_re %h, want %h", m_tdata[15:0], exp_out.re));
                if (m_tdata[31:16] !== exp_out.im)
                    report_mismatch($sformatf("out_im %h, want %h", m_tdata[31:16], exp_out.im));
                if (m_tlast !== exp_out.run_last)
                    report_mismatch($sformatf("run_last %b, want %b", m_tlast, exp_out.run_last));
                if (m_tuser !== exp_out.block_last)
                    report_mismatch($sformatf("block_last %b, want %b", m_tuser,
                                              exp_out.block_last));
            end
            outputs_checked++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles, %0d outputs outstanding",
                     idle_cycles, expected_outputs.size());
            $display("cubic_interpolating_resampler_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        row_t        row;
        bit          prev_write;
        int unsigned random_items;
        int unsigned in_len, out_len, count, pick;
        logic [23:0] value;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        prev_write = 1'b1;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                if (!prev_write)
                    settle();
                write_reg(row.index, row.value);
                prev_write = 1'b1;
            end else begin
                cfg_we <= 1'b0;
                send_sample(row.re, row.im, row.typed, row.want);
                prev_write = 1'b0;
            end
        end

        // Mostly consistent block settings with whole blocks of random samples;
        // the rest are arbitrary register values, including unused indexes.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 9) < 7) begin
                in_len  = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                out_len = $urandom_range(1, 3 * in_len);
                write_reg(REG_BLOCK_IN_LEN, 24'(in_len));
                write_reg(REG_BLOCK_OUT_LEN, 24'(out_len));
                write_reg(REG_POSITION_STEP, 24'((in_len << 16) / out_len));
                count = in_len * $urandom_range(1, 3);
                // Sometimes stop mid-block so the next setting lands part way through.
                if ($urandom_range(0, 5) == 0)
                    count += $urandom_range(1, in_len);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    pick  = $urandom_range(0, 3);
                    value = (pick == 0) ? 24'h000000 :
                            (pick == 1) ? 24'hFFFFFF : 24'($urandom());
                    write_reg(2'($urandom_range(0, 3)), value);
                end
                count = $urandom_range(1, 12);
            end
            cfg_we <= 1'b0;
            repeat (count) begin
                send_sample(draw_sample(), draw_sample(), 1'b0, NO_CHECK);
                random_items++;
            end
        end

        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("cubic_interpolating_resampler_top_tb: PASS");
        else
            $display("cubic_interpolating_resampler_top_tb: FAIL");
        $finish;
    end

endmodule
